// ----- hw/rtl/fpfa_pkg.sv -----
// Shared constants, codes and structs for the fixed partition fit allocator.
`default_nettype none

package fpfa_pkg;

  localparam int NUM_PART   = 64;
  localparam int SLOT_W     = 6;
  localparam int SIZE_W     = 16;
  localparam int WASTE_W    = 22;
  localparam int CNT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
  localparam logic [MODE_W-1:0] FIT_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd1;

  // Search token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] pos;
    logic [SIZE_W-1:0] best;
  } scan_tok_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              load;
    logic              clear;
    logic              mark;
    logic [SLOT_W-1:0] addr;
    logic [SIZE_W-1:0] data;
    logic [SIZE_W-1:0] req;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  limit;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fpfa_if.sv -----
// Channel interfaces: request items, result items and configuration writes.
`default_nettype none

interface fpfa_req_if;
  import fpfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot_index;
  logic [SIZE_W-1:0] size_value;
  modport source (output valid, command, slot_index, size_value, input ready);
  modport sink (input valid, command, slot_index, size_value, output ready);
endinterface

interface fpfa_res_if;
  import fpfa_pkg::*;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [SLOT_W-1:0]  chosen_slot;
  logic [SIZE_W-1:0]  leftover;
  logic [WASTE_W-1:0] total_waste;
  modport source (output valid, granted, chosen_slot, leftover, total_waste, input ready);
  modport sink (input valid, granted, chosen_slot, leftover, total_waste, output ready);
endinterface

interface fpfa_cfg_if;
  import fpfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fpfa_cell.sv -----
// One partition cell: holds a size and a used flag and updates the passing search token.
`default_nettype none

module fpfa_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  fpfa_pkg::cell_ctl_t  ctl,
  input  fpfa_pkg::scan_tok_t  tok_in,
  output fpfa_pkg::scan_tok_t  tok_out
);
  import fpfa_pkg::*;

  localparam logic [CNT_W-1:0]  IDX_CNT  = CNT_W'(IDX);
  localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(IDX);

  logic [SIZE_W-1:0] size;
  logic              used;
  logic [SIZE_W-1:0] left;
  logic              fits;
  logic              take;

  always_comb begin
    left = size - ctl.req;
    fits = tok_in.valid && (IDX_CNT < ctl.limit) && !used && (ctl.req <= size)
           && (ctl.mode != FIT_NONE);
    // First fit keeps the first candidate; the other modes replace on a strict win,
    // so ties stay with the lower index.
    take = fits && (!tok_in.found ||
                    (ctl.mode == FIT_BEST  && left < tok_in.best) ||
                    (ctl.mode == FIT_WORST && left > tok_in.best));
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.addr == IDX_SLOT) begin
      size <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.clear) begin
      used <= 1'b0;
    end else if (ctl.mark && ctl.addr == IDX_SLOT) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (take) begin
      tok_out <= '{valid: 1'b1, found: 1'b1, pos: IDX_SLOT, best: left};
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_partition_fit_allocator.sv -----
// Fixed partition allocator: a row of 64 partition cells scanned by a walking search token.
// Load and clear items take effect in the cycle they are accepted and give no result.
// An allocate item injects a search token that moves one partition cell per clock. The
// token crosses the cells, is captured at the end of the row, and a commit step then
// marks the partition, updates the saturating waste total and registers the result.
// Only one allocate is in flight at a time; the request channel is ready again in the
// cycle after the commit. A result that still waits in the output register holds the
// commit and so stalls the next item. Configuration writes are taken in any cycle and
// must only be issued while idle.
`default_nettype none

module fixed_partition_fit_allocator (
  input  wire         clk,
  input  wire         rst,
  fpfa_req_if.sink    req,
  fpfa_res_if.source  res,
  fpfa_cfg_if.sink    cfg
);
  import fpfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t             state;
  scan_tok_t          tok [NUM_PART+1];
  scan_tok_t          fin;
  cell_ctl_t          ctl;
  logic [SIZE_W-1:0]  req_q;
  logic [MODE_W-1:0]  fit_mode;
  logic [CNT_W-1:0]   part_count;
  logic [WASTE_W-1:0] waste;
  logic [WASTE_W:0]   waste_sum_wide;
  logic [WASTE_W-1:0] waste_next;
  logic               req_acc;
  logic               commit_go;
  logic [NUM_PART:0]  tok_valids;

  logic               out_valid;
  logic               out_granted;
  logic [SLOT_W-1:0]  out_slot;
  logic [SIZE_W-1:0]  out_left;
  logic [WASTE_W-1:0] out_total;

  assign req.ready       = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign res.valid       = out_valid;
  assign res.granted     = out_granted;
  assign res.chosen_slot = out_slot;
  assign res.leftover    = out_left;
  assign res.total_waste = out_total;

  always_comb begin
    req_acc   = req.valid && req.ready;
    commit_go = (state == ST_COMMIT) && (!out_valid || res.ready);

    ctl.load  = req_acc && (req.command == CMD_LOAD);
    ctl.clear = req_acc && (req.command == CMD_CLEAR);
    ctl.mark  = commit_go && fin.found;
    ctl.addr  = (state == ST_COMMIT) ? fin.pos : req.slot_index;
    ctl.data  = req.size_value;
    ctl.req   = req_q;
    ctl.mode  = fit_mode;
    ctl.limit = part_count;

    // The sum is one bit wider, so an overflow shows up as the carry bit and saturates to all ones.
    waste_sum_wide = {1'b0, waste} + (WASTE_W+1)'(fin.best);
    waste_next     = waste_sum_wide[WASTE_W] ? {WASTE_W{1'b1}}
                                             : waste_sum_wide[WASTE_W-1:0];
  end

  genvar g;
  generate
    for (g = 0; g < NUM_PART; g++) begin : g_cell
      fpfa_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1])
      );
    end
    for (g = 0; g <= NUM_PART; g++) begin : g_vld
      assign tok_valids[g] = tok[g].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tok[0].valid <= 1'b0;
      out_valid    <= 1'b0;
      waste        <= '0;
      fit_mode     <= FIT_FIRST;
      part_count   <= '0;
    end else begin
      tok[0].valid <= req_acc && (req.command == CMD_ALLOC);

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_FIT_MODE:   fit_mode   <= cfg.data[MODE_W-1:0];
          REG_PART_COUNT: part_count <= cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (commit_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            unique case (req.command)
              CMD_ALLOC: begin
                tok[0].found <= 1'b0;
                tok[0].pos   <= '0;
                tok[0].best  <= '0;
                req_q        <= req.size_value;
                state        <= ST_SCAN;
              end
              CMD_CLEAR: waste <= '0;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (tok[NUM_PART].valid) begin
            fin   <= tok[NUM_PART];
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            if (fin.found) begin
              out_granted <= 1'b1;
              out_slot    <= fin.pos;
              out_left    <= fin.best;
              out_total   <= waste_next;
              waste       <= waste_next;
            end else begin
              out_granted <= 1'b0;
              out_slot    <= '0;
              out_left    <= '0;
              out_total   <= waste;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // At most one search token travels the row of cells.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one search token in flight");

  // A token leaves the row only while the sequencer is waiting for it.
  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_PART].valid |-> state == ST_SCAN)
    else $error("search token arrived outside the scan state");

  // A freshly injected token always belongs to a scan in progress.
  a_inject_scan: assert property (@(posedge clk) disable iff (rst)
    tok[0].valid |-> state == ST_SCAN)
    else $error("search token injected outside the scan state");

  // A miss reports neither a slot nor a leftover.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_slot == '0 && out_left == '0))
    else $error("miss result carries a slot or leftover");

endmodule

`default_nettype wire
